### rtl/core/are_pkg.sv
// Package for the radial extent block: widths, register codes, queue item and FSM types.
// No dependencies; every other file of the block imports it.
`default_nettype none

package are_pkg;

    localparam int COORD_WIDTH_DEF   = 24;
    localparam int DIR_FRAC_BITS_DEF = 15;
    localparam int DIR_WIDTH         = 16;
    localparam logic signed [DIR_WIDTH-1:0] DIR_Z_RESET = 16'sh7FFF;

    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W_DEF = 24;

    localparam int COMP_BITS  = 26;
    localparam int SQ_W       = 2 * COMP_BITS;
    localparam int RAD_W      = 29;
    localparam int RAD_SHIFT  = 8;
    localparam int OPND_W     = SQ_W + RAD_SHIFT;
    localparam int ROOT_W     = OPND_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int SQRT_CNT_W = $clog2(ROOT_W);

    localparam int FRONT_STAGES = 7;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_AXIS_POINT_X = 3'd0,
        REG_AXIS_POINT_Y = 3'd1,
        REG_AXIS_POINT_Z = 3'd2,
        REG_AXIS_DIR_X   = 3'd3,
        REG_AXIS_DIR_Y   = 3'd4,
        REG_AXIS_DIR_Z   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [SQ_W-1:0] sq;
        logic            last;
    } queue_item_t;

    typedef enum logic {
        BACK_ACCUM,
        BACK_ROOT
    } back_state_t;

endpackage

`default_nettype wire

### rtl/core/are_ifs.sv
// Valid/ready channel interfaces: configuration writes, input points and results.
// Depends on are_pkg.
`default_nettype none

interface are_cfg_if #(
    parameter int DATA_WIDTH = are_pkg::CFG_DATA_W_DEF
);
    import are_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [DATA_WIDTH-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

interface are_point_if #(
    parameter int COORD_WIDTH = are_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic                          last_point;

    modport source (output valid, point_x, point_y, point_z, last_point, input ready);
    modport sink (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface are_result_if;
    import are_pkg::*;

    logic             valid;
    logic             ready;
    logic [RAD_W-1:0] max_radius;
    logic [RAD_W-1:0] min_radius;

    modport source (output valid, max_radius, min_radius, input ready);
    modport sink (input valid, max_radius, min_radius, output ready);
endinterface

`default_nettype wire

### rtl/core/axis_radial_extent_min_max.sv
// Throughput: one point per cycle within a set while the queue has room; the end of a set
// holds the back end in its bit-serial square root, while the seven front stages and the
// four-entry queue take up to eleven more points before the input stalls.
// Reset clears the pipeline, the queue and the set state, sets the axis to the origin
// and the direction to (0, 0, 32767); there is no clearing pass.
`default_nettype none

module axis_radial_extent_min_max #(
    parameter int COORD_WIDTH   = are_pkg::COORD_WIDTH_DEF,
    parameter int DIR_FRAC_BITS = are_pkg::DIR_FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    are_cfg_if.sink      cfg,
    are_point_if.sink    points,
    are_result_if.source results
);
    import are_pkg::*;

    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    queue_item_t q_in;
    queue_item_t q_out;

    are_front #(
        .COORD_WIDTH   (COORD_WIDTH),
        .DIR_FRAC_BITS (DIR_FRAC_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .points (points),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (q_in)
    );

    are_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .pop_item  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    are_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_item  (q_out),
        .q_pop   (q_pop),
        .results (results)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("Queue written while full.");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("Queue read while empty.");

    a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        !points.ready |-> q_full)
        else $error("Input stalled while the queue has room.");

    a_min_not_above_max: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.min_radius <= results.max_radius))
        else $error("Smallest radius exceeds largest radius.");

endmodule

`default_nettype wire

### rtl/core/are_front.sv
// Front end: configuration registers and a seven-stage pipeline that turns each point
// into its squared radial distance and pushes it into the queue. Depends on are_pkg.
`default_nettype none

module are_front #(
    parameter int COORD_WIDTH   = are_pkg::COORD_WIDTH_DEF,
    parameter int DIR_FRAC_BITS = are_pkg::DIR_FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    are_cfg_if.sink             cfg,
    are_point_if.sink           points,
    input  logic                q_full,
    output logic                q_push,
    output are_pkg::queue_item_t q_item
);
    import are_pkg::*;

    localparam int DW   = COORD_WIDTH + 1;
    localparam int UW   = (DIR_FRAC_BITS + 2 > DIR_WIDTH) ? DIR_FRAC_BITS + 2 : DIR_WIDTH;
    localparam int P1W  = DW + UW;
    localparam int SUMW = P1W + 2;
    localparam int PW   = SUMW + 1 - DIR_FRAC_BITS;
    localparam int P2W  = PW + UW;
    localparam int QW   = P2W + 1 - DIR_FRAC_BITS;
    localparam int RCW  = ((DW > QW) ? DW : QW) + 1;
    localparam int MW   = (RCW > COMP_BITS + 1) ? RCW : COMP_BITS + 1;

    localparam logic [UW-1:0]     U_ONE  = UW'(1) << DIR_FRAC_BITS;
    localparam logic [SUMW:0]     HALF_S = (SUMW + 1)'(1) << (DIR_FRAC_BITS - 1);
    localparam logic [P2W:0]      HALF_Q = (P2W + 1)'(1) << (DIR_FRAC_BITS - 1);
    localparam logic [SQ_W+1:0]   SQ_LIMIT = (SQ_W + 2)'({SQ_W{1'b1}});

    logic signed [COORD_WIDTH-1:0] axis_reg [3];
    logic signed [DIR_WIDTH-1:0]   dir_reg [3];
    logic signed [UW-1:0]          u_vec [3];
    logic                          dir_zero;

    logic                    en;
    logic                    accept;
    logic [FRONT_STAGES-1:0] vld_reg;
    logic [FRONT_STAGES-1:0] last_reg;

    logic signed [DW-1:0]   d1_next [3];
    logic signed [DW-1:0]   d1_reg [3];
    logic signed [DW-1:0]   d2_reg [3];
    logic signed [DW-1:0]   d3_reg [3];
    logic signed [DW-1:0]   d4_reg [3];
    logic signed [P1W-1:0]  p_next [3];
    logic signed [P1W-1:0]  p_reg [3];
    logic signed [SUMW-1:0] dot_sum;
    logic signed [SUMW:0]   dot_half;
    logic signed [PW-1:0]   proj_next;
    logic signed [PW-1:0]   proj_reg;
    logic signed [P2W-1:0]  q_next [3];
    logic signed [P2W-1:0]  q_reg [3];
    logic signed [P2W:0]    q_half [3];
    logic signed [QW-1:0]   q_round [3];
    logic signed [RCW-1:0]  rc [3];
    logic signed [MW-1:0]   rc_ext [3];
    logic [MW-1:0]          rc_mag [3];
    logic [COMP_BITS-1:0]   mag_next [3];
    logic [COMP_BITS-1:0]   mag_reg [3];
    logic                   sat5_next;
    logic                   sat5_reg;
    logic [SQ_W-1:0]        sq6_next [3];
    logic [SQ_W-1:0]        sq6_reg [3];
    logic                   sat6_reg;
    logic [SQ_W+1:0]        sq_sum;
    logic [SQ_W-1:0]        sq7_next;
    logic [SQ_W-1:0]        sq7_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg[0] <= '0;
            axis_reg[1] <= '0;
            axis_reg[2] <= '0;
            dir_reg[0]  <= '0;
            dir_reg[1]  <= '0;
            dir_reg[2]  <= DIR_Z_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_AXIS_POINT_X: axis_reg[0] <= cfg.data[COORD_WIDTH-1:0];
                REG_AXIS_POINT_Y: axis_reg[1] <= cfg.data[COORD_WIDTH-1:0];
                REG_AXIS_POINT_Z: axis_reg[2] <= cfg.data[COORD_WIDTH-1:0];
                REG_AXIS_DIR_X:   dir_reg[0]  <= cfg.data[DIR_WIDTH-1:0];
                REG_AXIS_DIR_Y:   dir_reg[1]  <= cfg.data[DIR_WIDTH-1:0];
                REG_AXIS_DIR_Z:   dir_reg[2]  <= cfg.data[DIR_WIDTH-1:0];
                default:          ;
            endcase
        end
    end

    // An all-zero direction stands for the exact unit vector along z.
    always_comb
    begin
        dir_zero = (dir_reg[0] == '0) && (dir_reg[1] == '0) && (dir_reg[2] == '0);
        u_vec[0] = UW'(dir_reg[0]);
        u_vec[1] = UW'(dir_reg[1]);
        u_vec[2] = dir_zero ? $signed(U_ONE) : UW'(dir_reg[2]);
    end

    assign en            = !(vld_reg[FRONT_STAGES-1] && q_full);
    assign points.ready  = en;
    assign accept        = points.valid && en;
    assign q_push        = vld_reg[FRONT_STAGES-1] && !q_full;
    assign q_item.sq     = sq7_reg;
    assign q_item.last   = last_reg[FRONT_STAGES-1];

    always_comb
    begin
        d1_next[0] = DW'(points.point_x) - DW'(axis_reg[0]);
        d1_next[1] = DW'(points.point_y) - DW'(axis_reg[1]);
        d1_next[2] = DW'(points.point_z) - DW'(axis_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            p_next[i] = P1W'(d1_reg[i]) * P1W'(u_vec[i]);
        end
        dot_sum   = SUMW'(p_reg[0]) + SUMW'(p_reg[1]) + SUMW'(p_reg[2]);
        dot_half  = (SUMW + 1)'(dot_sum) + $signed(HALF_S);
        proj_next = PW'(dot_half >>> DIR_FRAC_BITS);
        sat5_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            q_next[i]   = P2W'(proj_reg) * P2W'(u_vec[i]);
            q_half[i]   = (P2W + 1)'(q_reg[i]) + $signed(HALF_Q);
            q_round[i]  = QW'(q_half[i] >>> DIR_FRAC_BITS);
            rc[i]       = RCW'(d4_reg[i]) - RCW'(q_round[i]);
            rc_ext[i]   = MW'(rc[i]);
            rc_mag[i]   = rc_ext[i][MW-1] ? MW'(-rc_ext[i]) : MW'(rc_ext[i]);
            mag_next[i] = rc_mag[i][COMP_BITS-1:0];
            sat5_next   = sat5_next || (rc_mag[i][MW-1:COMP_BITS] != '0);
            sq6_next[i] = SQ_W'(mag_reg[i]) * SQ_W'(mag_reg[i]);
        end
        sq_sum   = (SQ_W + 2)'(sq6_reg[0]) + (SQ_W + 2)'(sq6_reg[1])
                 + (SQ_W + 2)'(sq6_reg[2]);
        sq7_next = (sat6_reg || (sq_sum > SQ_LIMIT)) ? '1 : sq_sum[SQ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg <= {last_reg[FRONT_STAGES-2:0], points.last_point};
            d1_reg   <= d1_next;
            d2_reg   <= d1_reg;
            d3_reg   <= d2_reg;
            d4_reg   <= d3_reg;
            p_reg    <= p_next;
            proj_reg <= proj_next;
            q_reg    <= q_next;
            mag_reg  <= mag_next;
            sat5_reg <= sat5_next;
            sq6_reg  <= sq6_next;
            sat6_reg <= sat5_reg;
            sq7_reg  <= sq7_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/are_fifo.sv
// Four-entry queue of squared distances between the front pipeline and the back end.
// Depends on are_pkg.
`default_nettype none

module are_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  are_pkg::queue_item_t push_item,
    input  logic                 pop,
    output are_pkg::queue_item_t pop_item,
    output logic                 full,
    output logic                 empty
);
    import are_pkg::*;

    queue_item_t       entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full     = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/are_sqrt.sv
// Iterative integer square root, one result bit per cycle, of a squared distance
// scaled by 256; the root saturates to the radius width. Depends on are_pkg.
`default_nettype none

module are_sqrt (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [are_pkg::SQ_W-1:0] operand,
    output logic                     busy,
    output logic [are_pkg::RAD_W-1:0] root
);
    import are_pkg::*;

    logic                  busy_reg;
    logic [SQRT_CNT_W-1:0] cnt_reg;
    logic [OPND_W-1:0]     op_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [REM_W+1:0]      rem_shift;
    logic [REM_W+1:0]      trial;
    logic [REM_W-1:0]      rem_next;
    logic [ROOT_W-1:0]     root_next;

    always_comb
    begin
        rem_shift = {rem_reg, op_reg[OPND_W-1:OPND_W-2]};
        trial     = (REM_W + 2)'({root_reg, 2'b01});
        if (rem_shift >= trial)
        begin
            rem_next  = REM_W'(rem_shift - trial);
            root_next = {root_reg[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_shift[REM_W-1:0];
            root_next = {root_reg[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= SQRT_CNT_W'(ROOT_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg   <= {operand, {RAD_SHIFT{1'b0}}};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            op_reg   <= op_reg << 2;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign busy = busy_reg;
    assign root = root_reg[ROOT_W-1] ? '1 : root_reg[RAD_W-1:0];

endmodule

`default_nettype wire

### rtl/core/are_back.sv
// Back end: tracks the largest and smallest squared distance of a set, takes the two
// roots at the end of the set and holds the result for transfer. Depends on are_pkg, are_sqrt.
`default_nettype none

module are_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  are_pkg::queue_item_t q_item,
    output logic                 q_pop,
    are_result_if.source         results
);
    import are_pkg::*;

    back_state_t      state_reg;
    back_state_t      state_next;
    logic             started_reg;
    logic [SQ_W-1:0]  max_sq_reg;
    logic [SQ_W-1:0]  min_sq_reg;
    logic [SQ_W-1:0]  max_sq_next;
    logic [SQ_W-1:0]  min_sq_next;
    logic             res_valid_reg;
    logic [RAD_W-1:0] max_rad_reg;
    logic [RAD_W-1:0] min_rad_reg;
    logic             root_start;
    logic             res_load;
    logic             out_free;
    logic             roots_done;
    logic             max_busy;
    logic             min_busy;
    logic [RAD_W-1:0] max_root;
    logic [RAD_W-1:0] min_root;

    assign out_free   = !res_valid_reg || results.ready;
    assign roots_done = !max_busy && !min_busy;

    always_comb
    begin
        max_sq_next = (!started_reg || (q_item.sq > max_sq_reg)) ? q_item.sq : max_sq_reg;
        min_sq_next = (!started_reg || (q_item.sq < min_sq_reg)) ? q_item.sq : min_sq_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BACK_ACCUM:
            begin
                if (!q_empty && q_item.last)
                begin
                    state_next = BACK_ROOT;
                end
            end
            BACK_ROOT:
            begin
                if (roots_done && out_free)
                begin
                    state_next = BACK_ACCUM;
                end
            end
            default: state_next = BACK_ACCUM;
        endcase
    end

    always_comb
    begin
        q_pop      = 1'b0;
        root_start = 1'b0;
        res_load   = 1'b0;
        unique case (state_reg)
            BACK_ACCUM:
            begin
                q_pop      = !q_empty;
                root_start = !q_empty && q_item.last;
            end
            BACK_ROOT:
            begin
                res_load = roots_done && out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_ACCUM;
            started_reg   <= 1'b0;
            max_sq_reg    <= '0;
            min_sq_reg    <= '1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                if (q_item.last)
                begin
                    started_reg <= 1'b0;
                    max_sq_reg  <= '0;
                    min_sq_reg  <= '1;
                end
                else
                begin
                    started_reg <= 1'b1;
                    max_sq_reg  <= max_sq_next;
                    min_sq_reg  <= min_sq_next;
                end
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            max_rad_reg <= max_root;
            min_rad_reg <= min_root;
        end
    end

    are_sqrt u_max_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (root_start),
        .operand (max_sq_next),
        .busy    (max_busy),
        .root    (max_root)
    );

    are_sqrt u_min_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (root_start),
        .operand (min_sq_next),
        .busy    (min_busy),
        .root    (min_root)
    );

    assign results.valid      = res_valid_reg;
    assign results.max_radius = max_rad_reg;
    assign results.min_radius = min_rad_reg;

endmodule

`default_nettype wire
